// File: rtl/hfq_pkg.sv
package hfq_pkg;

  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CELL_W      = 8;
  localparam int SIDE_W      = 9;
  localparam int MAX_SIDE    = 256;
  localparam int SPACE_W     = 16;
  localparam int COORD_W     = 24;
  localparam int PIX_W       = 32;
  localparam int HEIGHT_W    = 22;
  localparam int ACC_W       = SPACE_W + CELL_W;
  localparam int DSR_W       = 20;
  localparam int CNT_W       = 5;
  localparam int FRAC_SHIFT  = 17;
  localparam int FIN_W       = ACC_W + FRAC_SHIFT;

  localparam logic [CNT_W-1:0] COORD_STEPS = CNT_W'(COORD_W);
  localparam logic [CNT_W-1:0] FIN_STEPS   = CNT_W'(HEIGHT_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ACROSS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                command;
    logic [ADDR_W-1:0]   pixel_address;
    logic [PIX_W-1:0]    pixel_word;
    logic [COORD_W-1:0]  query_x;
    logic [COORD_W-1:0]  query_z;
  } hfq_in_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] surface_height;
    logic                outside_grid;
  } hfq_out_t;

  typedef struct packed {
    logic                start;
    logic [DSR_W-1:0]    divisor;
    logic [DSR_W-1:0]    rem_init;
    logic [COORD_W-1:0]  dividend;
    logic [CNT_W-1:0]    steps;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [COORD_W-1:0]  quot;
    logic [DSR_W-1:0]    rem;
  } div_rsp_t;

endpackage

// File: rtl/hfq_ram.sv
module hfq_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [hfq_pkg::ADDR_W-1:0] waddr,
  input  logic [hfq_pkg::CELL_W-1:0] wdata,
  input  logic [hfq_pkg::ADDR_W-1:0] raddr,
  output logic [hfq_pkg::CELL_W-1:0] rdata
);
  import hfq_pkg::*;

  logic [CELL_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hfq_div.sv
module hfq_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hfq_pkg::div_req_t req,
  output hfq_pkg::div_rsp_t rsp
);
  import hfq_pkg::*;

  logic [DSR_W-1:0]   rem_r;
  logic [DSR_W-1:0]   dsr_r;
  logic [COORD_W-1:0] dq_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [DSR_W:0]     shifted;
  logic [DSR_W:0]     trial;
  logic               fits;

  assign shifted = {rem_r, dq_r[COORD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dsr_r <= req.divisor;
      dq_r  <= req.dividend;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      dq_r  <= {dq_r[COORD_W-2:0], fits};
    end
  end

  assign rsp.done = busy_r && (cnt_r == CNT_W'(1));
  assign rsp.quot = dq_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/heightfield_height_query.sv
// Load: a word is written when accepted, ready again the next cycle.
// Query inside the grid: divide x, divide z, read three corners, divide for the final scale,
//   each on the shared restoring divider (24 steps for x, 24 for z, 22 for the final scale).
// Query outside the grid: skips the corner reads and the final scale. One query at a time;
//   the next is taken once the result register has been loaded.
// Reset (rst_n, synchronous, active low): config back to 256/256/256, store contents undefined.
module heightfield_height_query (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hfq_pkg::hfq_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hfq_pkg::hfq_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hfq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XW   = 3'd1;
  localparam logic [2:0] S_ZS   = 3'd2;
  localparam logic [2:0] S_ZW   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FS   = 3'd6;
  localparam logic [2:0] S_FW   = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [SIDE_W-1:0]    across_r, deep_r;
  logic [SPACE_W-1:0]   spacing_r;
  logic [SIDE_W-1:0]    nx_r, nz_r;
  logic [SPACE_W-1:0]   s_r;
  logic [COORD_W-1:0]   qz_r;
  logic [COORD_W-1:0]   cx_r;
  logic [SPACE_W-1:0]   rx_r;
  logic                 upper_r;
  logic                 outside_r;
  logic [ADDR_W-1:0]    base_lo_r;
  logic [SPACE_W-1:0]   w_r [3];
  logic [ACC_W-1:0]     acc_r;
  logic [1:0]           k_r;
  logic                 fin_done_r;
  logic                 out_valid_r;
  hfq_out_t             out_data_r;

  logic                 in_acc, query_acc, load_we, fin_ok;
  logic [SPACE_W-1:0]   s_eff;
  logic [SIDE_W-1:0]    nx_eff, nz_eff;
  div_req_t             dreq;
  div_rsp_t             drsp;
  logic [COORD_W-1:0]   cz;
  logic [SPACE_W-1:0]   rz;
  logic [COORD_W:0]     cx1, cz1;
  logic                 outside;
  logic [SPACE_W:0]     rsum, s17;
  logic                 upper;
  logic [SIDE_W-1:0]    prow;
  logic [2*SIDE_W-1:0]  base_full;
  logic [ADDR_W-1:0]    base_hi, col0, col1, raddr;
  logic [CELL_W-1:0]    rdata;
  logic [1:0]           wsel;
  logic [ACC_W-1:0]     prod;
  logic [FIN_W-1:0]     dfin;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (in_data.command == CMD_QUERY);
  assign load_we   = in_acc && (in_data.command == CMD_LOAD);

  assign s_eff  = (spacing_r == '0) ? SPACE_W'(1) : spacing_r;
  assign nx_eff = (across_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : across_r;
  assign nz_eff = (deep_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : deep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      across_r  <= SIDE_W'(256);
      deep_r    <= SIDE_W'(256);
      spacing_r <= SPACE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACROSS:  across_r  <= cfg_data[SIDE_W-1:0];
        CFG_DEEP:    deep_r    <= cfg_data[SIDE_W-1:0];
        CFG_SPACING: spacing_r <= cfg_data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  hfq_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_data.pixel_address),
    .wdata (in_data.pixel_word[CELL_W-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  hfq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign dfin = {acc_r, FRAC_SHIFT'(0)} + FIN_W'({3'b0, s_r} * 19'd7);

  always_comb begin
    dreq          = '0;
    dreq.divisor  = DSR_W'(s_r);
    dreq.steps    = COORD_STEPS;
    dreq.dividend = qz_r;
    case (state_r)
      S_IDLE: begin
        dreq.start    = query_acc;
        dreq.divisor  = DSR_W'(s_eff);
        dreq.dividend = in_data.query_x;
      end
      S_ZS: begin
        dreq.start = 1'b1;
      end
      S_FS: begin
        dreq.start    = 1'b1;
        dreq.divisor  = DSR_W'({4'b0, s_r} * 20'd14);
        dreq.rem_init = DSR_W'(dfin[FIN_W-1:HEIGHT_W]);
        dreq.dividend = {dfin[HEIGHT_W-1:0], 2'b00};
        dreq.steps    = FIN_STEPS;
      end
      default: ;
    endcase
  end

  // z results are read straight from the idle divider
  assign cz      = drsp.quot;
  assign rz      = drsp.rem[SPACE_W-1:0];
  assign cx1     = {1'b0, cx_r} + (COORD_W+1)'(1);
  assign cz1     = {1'b0, cz} + (COORD_W+1)'(1);
  assign outside = (cx1 >= (COORD_W+1)'(nx_r)) || (cz1 >= (COORD_W+1)'(nz_r));
  assign rsum    = {1'b0, rx_r} + {1'b0, rz};
  assign s17     = {1'b0, s_r};
  assign upper   = rsum > s17;
  assign prow    = nz_r - SIDE_W'(1) - {1'b0, cz[CELL_W-1:0]};
  assign base_full = prow * nx_r;

  assign base_hi = base_lo_r - ADDR_W'(nx_r);
  assign col0    = ADDR_W'(cx_r[CELL_W-1:0]);
  assign col1    = col0 + ADDR_W'(1);

  always_comb begin
    case (k_r)
      2'd0:    raddr = base_hi + col0;
      2'd1:    raddr = base_lo_r + col1;
      2'd2:    raddr = upper_r ? (base_hi + col1) : (base_lo_r + col0);
      default: raddr = base_lo_r;
    endcase
  end

  assign wsel = k_r - 2'd1;
  assign prod = w_r[wsel] * rdata;

  assign fin_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (query_acc) state_nxt = S_XW;
      S_XW:   if (drsp.done) state_nxt = S_ZS;
      S_ZS:   state_nxt = S_ZW;
      S_ZW:   if (drsp.done) state_nxt = S_CHK;
      S_CHK:  state_nxt = outside ? S_FW : S_RD;
      S_RD:   if (k_r == 2'd3) state_nxt = S_FS;
      S_FS:   state_nxt = S_FW;
      S_FW:   if ((outside_r || fin_done_r) && fin_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      fin_done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FW && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RD) begin
        k_r <= k_r + 2'd1;
      end else begin
        k_r <= 2'd0;
      end
      // final quotient is settled the cycle after done
      fin_done_r <= (state_r == S_FW) && (fin_done_r || drsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      s_r  <= s_eff;
      nx_r <= nx_eff;
      nz_r <= nz_eff;
      qz_r <= in_data.query_z;
    end
    if (state_r == S_ZS) begin
      cx_r <= drsp.quot;
      rx_r <= drsp.rem[SPACE_W-1:0];
    end
    if (state_r == S_CHK) begin
      outside_r <= outside;
      upper_r   <= upper;
      base_lo_r <= base_full[ADDR_W-1:0];
      acc_r     <= '0;
      if (upper) begin
        w_r[0] <= s_r - rx_r;
        w_r[1] <= s_r - rz;
        w_r[2] <= SPACE_W'(rsum - s17);
      end else begin
        w_r[0] <= rz;
        w_r[1] <= rx_r;
        w_r[2] <= SPACE_W'(s17 - rsum);
      end
    end
    if (state_r == S_RD && k_r != 2'd0) begin
      acc_r <= acc_r + prod;
    end
    if (state_r == S_FW && state_nxt == S_IDLE) begin
      out_data_r.outside_grid   <= outside_r;
      out_data_r.surface_height <= outside_r ? '0 : drsp.quot[HEIGHT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: verif/tb_heightfield_height_query.sv
module tb_heightfield_height_query;
  timeunit 1ns;
  timeprecision 1ps;

  import hfq_pkg::*;

  typedef struct packed {
    logic             in_grid;
    logic             upper;
    logic [16:0]      span;
    logic [2:0][16:0] corner;
    logic [2:0][16:0] weight;
  } triangle_t;

  typedef struct packed {
    hfq_in_t word;
    logic    hold;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  hfq_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hfq_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SIDE_W-1:0]  model_across = 9'd256;
  logic [SIDE_W-1:0]  model_deep = 9'd256;
  logic [SPACE_W-1:0] model_spacing = 16'd256;
  bit [CELL_W-1:0]    height_mem [STORE_DEPTH];
  bit                 loaded_mem [STORE_DEPTH];

  pending_t pending_words [$];
  hfq_out_t expected_heights [$];

  int items_queued = 0;
  int load_count = 0;
  int query_count = 0;
  int upper_count = 0;
  int lower_count = 0;
  int outside_count = 0;
  int settings_count = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit out_armed = 1'b0;

  heightfield_height_query uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned side_of(logic [SIDE_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : v;
  endfunction

  function automatic longint unsigned spacing_now();
    return (model_spacing == 0) ? 1 : model_spacing;
  endfunction

  // bitmap rows are stored bottom-up relative to grid rows
  function automatic logic [16:0] vertex_index(longint unsigned col, longint unsigned row,
                                               longint unsigned nx, longint unsigned nz);
    return 17'((nz - 1 - row) * nx + col);
  endfunction

  function automatic triangle_t locate_triangle(logic [COORD_W-1:0] qx,
                                                logic [COORD_W-1:0] qz);
    longint unsigned nx, nz, s, cx, cz, rx, rz;
    triangle_t hit;
    nx = side_of(model_across);
    nz = side_of(model_deep);
    s = spacing_now();
    cx = qx / s;
    rx = qx % s;
    cz = qz / s;
    rz = qz % s;
    hit = '0;
    hit.span = 17'(s);
    hit.in_grid = (cx + 1 < nx) && (cz + 1 < nz);
    hit.upper = (rx + rz > s);
    if (hit.upper) begin
      hit.corner[0] = vertex_index(cx, cz + 1, nx, nz);
      hit.weight[0] = 17'(s - rx);
      hit.corner[1] = vertex_index(cx + 1, cz, nx, nz);
      hit.weight[1] = 17'(s - rz);
      hit.corner[2] = vertex_index(cx + 1, cz + 1, nx, nz);
      hit.weight[2] = 17'(rx + rz - s);
    end else begin
      hit.corner[0] = vertex_index(cx, cz + 1, nx, nz);
      hit.weight[0] = 17'(rz);
      hit.corner[1] = vertex_index(cx + 1, cz, nx, nz);
      hit.weight[1] = 17'(rx);
      hit.corner[2] = vertex_index(cx, cz, nx, nz);
      hit.weight[2] = 17'(s - rx - rz);
    end
    return hit;
  endfunction

  function automatic hfq_out_t predict_height(triangle_t hit);
    longint unsigned num;
    hfq_out_t r;
    r = '0;
    num = 0;
    if (!hit.in_grid) begin
      r.outside_grid = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (hit.corner[k] < STORE_DEPTH) num += hit.weight[k] * height_mem[hit.corner[k]];
      end
      // height/7 in Q6.16, halves rounded up
      r.surface_height = HEIGHT_W'((num * 131072 + 7 * hit.span) / (14 * hit.span));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    triangle_t hit;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      if (in_data.command == CMD_LOAD) begin
        height_mem[in_data.pixel_address] = in_data.pixel_word[CELL_W-1:0];
        load_count++;
      end else begin
        hit = locate_triangle(in_data.query_x, in_data.query_z);
        expected_heights.push_back(predict_height(hit));
        query_count++;
        if (!hit.in_grid) outside_count++;
        else if (hit.upper) upper_count++;
        else lower_count++;
      end
    end
  end

  always @(posedge clk) begin
    hfq_out_t want;
    out_taken = rst_n && out_valid && out_ready;
    if (out_taken) begin
      if (expected_heights.size() == 0) begin
        $error("result word with no query pending: surface_height %0d outside_grid %0d",
               out_data.surface_height, out_data.outside_grid);
        mismatches++;
      end else begin
        want = expected_heights.pop_front();
        if (out_data.surface_height !== want.surface_height) begin
          $error("surface_height expected %0d actual %0d",
                 want.surface_height, out_data.surface_height);
          mismatches++;
        end
        if (out_data.outside_grid !== want.outside_grid) begin
          $error("outside_grid expected %0d actual %0d",
                 want.outside_grid, out_data.outside_grid);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    logic     next_valid;
    hfq_in_t  next_data;
    pending_t head;
    next_valid = in_valid;
    next_data = in_data;
    if (in_taken) begin
      next_valid = 1'b0;
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      in_gap = in_calm ? 0 : $urandom_range(0, 8);
    end
    if (rst_n && !next_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].hold && expected_heights.size() > 0)) begin
        head = pending_words.pop_front();
        next_data = head.word;
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
    in_data <= next_data;
  end

  always @(negedge clk) begin
    if (out_taken) out_armed = 1'b0;
    if (out_valid && !out_armed) begin
      out_armed = 1'b1;
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_stall = out_calm ? 0 : $urandom_range(0, 8);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_word(hfq_in_t w, bit hold);
    pending_t p;
    p.word = w;
    p.hold = hold;
    pending_words.push_back(p);
    items_queued++;
    if (w.command == CMD_LOAD) loaded_mem[w.pixel_address] = 1'b1;
  endtask

  task automatic queue_load(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
    hfq_in_t w;
    w.command = CMD_LOAD;
    w.pixel_address = addr;
    w.pixel_word = pix;
    w.query_x = COORD_W'($urandom);
    w.query_z = COORD_W'($urandom);
    queue_word(w, 1'b0);
  endtask

  // any corner a query reads gets loaded first
  task automatic queue_query(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qz, bit hold);
    triangle_t hit;
    hfq_in_t   w;
    hit = locate_triangle(qx, qz);
    if (hit.in_grid) begin
      for (int k = 0; k < 3; k++) begin
        if (!loaded_mem[hit.corner[k]]) queue_load(ADDR_W'(hit.corner[k]), $urandom);
      end
    end
    w.command = CMD_QUERY;
    w.pixel_address = ADDR_W'($urandom);
    w.pixel_word = $urandom;
    w.query_x = qx;
    w.query_z = qz;
    queue_word(w, hold);
  endtask

  task automatic random_phase(int budget);
    int stop;
    int pick;
    longint unsigned nx, nz, s, cx, cz, rx, rz;
    stop = items_queued + budget;
    nx = side_of(model_across);
    nz = side_of(model_deep);
    s = spacing_now();
    while (items_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_load(ADDR_W'($urandom), $urandom);
      end else if (pick < 30 || nx < 2 || nz < 2) begin
        queue_query(COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 99) == 0);
      end else if (pick < 40) begin
        // last vertex column or row: no cell beyond it
        cx = $urandom_range(0, nx - 1);
        cz = $urandom_range(0, nz - 1);
        if ($urandom_range(0, 1)) cx = nx - 1;
        else cz = nz - 1;
        rx = $urandom_range(0, s - 1);
        rz = $urandom_range(0, s - 1);
        queue_query(COORD_W'(cx * s + rx), COORD_W'(cz * s + rz), 1'b0);
      end else begin
        cx = $urandom_range(0, nx - 2);
        cz = $urandom_range(0, nz - 2);
        if ($urandom_range(0, 1)) begin
          cx = cx % 4;
          cz = cz % 4;
        end
        rx = $urandom_range(0, s - 1);
        rz = $urandom_range(0, s - 1);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          rx = 0;
          rz = 0;
        end else if (pick < 3 && s > 1) begin
          rx = $urandom_range(1, s - 1);
          rz = s - rx;
          if (pick == 2 && rx > 1) rz++;
        end
        queue_query(COORD_W'(cx * s + rx), COORD_W'(cz * s + rz),
                    $urandom_range(0, 99) == 0);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_heights.size() > 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_ACROSS:  model_across = val[SIDE_W-1:0];
      CFG_DEEP:    model_deep = val[SIDE_W-1:0];
      CFG_SPACING: model_spacing = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic new_setting(logic [CFG_DATA_W-1:0] across, logic [CFG_DATA_W-1:0] deep,
                             logic [CFG_DATA_W-1:0] spacing);
    wait_idle();
    write_register(CFG_ACROSS, across);
    write_register(CFG_DEEP, deep);
    write_register(CFG_SPACING, spacing);
    settings_count++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_count = 1;

    // reset grid: 256 x 256 vertices, spacing 1.0
    queue_load(16'h0000, 32'hFFFF_FFFF);
    queue_load(16'hFFFF, 32'h0000_00FF);
    queue_load(16'hFFFF, 32'hFFFF_FF00);
    for (int c = 254; c < 256; c++) begin
      for (int r = 254; r < 256; r++) begin
        queue_load(ADDR_W'(vertex_index(c, r, 256, 256)), 32'hFFFF_FFFF);
      end
    end
    queue_query(24'd0, 24'd0, 1'b0);
    queue_query(COORD_W'(254 * 256 + 255), COORD_W'(254 * 256 + 255), 1'b0);
    queue_query(COORD_W'(254 * 256 + 10), COORD_W'(254 * 256 + 20), 1'b0);
    queue_query(COORD_W'(10 * 256 + 100), COORD_W'(20 * 256 + 156), 1'b1);
    queue_query(COORD_W'(10 * 256 + 100), COORD_W'(20 * 256 + 157), 1'b0);
    queue_query(COORD_W'(255 * 256 - 1), 24'd0, 1'b0);
    queue_query(24'hFF_FFFF, 24'd0, 1'b0);
    queue_query(24'd0, COORD_W'(255 * 256), 1'b0);
    queue_query(24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
    random_phase(230);

    new_setting(16'd2, 16'd2, 16'd1);
    random_phase(120);
    new_setting(16'd256, 16'd256, 16'd65535);
    random_phase(180);
    // counts above the maximum saturate, zero spacing acts as one
    new_setting(16'd300, 16'd511, 16'd0);
    random_phase(180);
    new_setting(16'd1, 16'd40, 16'd16);
    random_phase(50);
    new_setting(16'd64, 16'd0, 16'd512);
    random_phase(40);
    for (int p = 0; p < 3; p++) begin
      new_setting(CFG_DATA_W'($urandom_range(2, 256)), CFG_DATA_W'($urandom_range(2, 256)),
                  ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 65535))
                                              : CFG_DATA_W'($urandom_range(1, 1024)));
      random_phase(250);
    end

    wait_idle();
    $display("Ran %0d pixel loads and %0d height queries (%0d upper, %0d lower, %0d off grid)",
             load_count, query_count, upper_count, lower_count, outside_count);
    $display("over %0d grid settings including minimum, maximum and saturated sizes.",
             settings_count);
    if (mismatches == 0) begin
      $display("heightfield_height_query test passed");
    end else begin
      $display("heightfield_height_query test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("heightfield_height_query test failed");
    $finish;
  end

endmodule
